// File: src/eihs_pkg.sv
// ----------------------------------------------------------------------------
// eihs_pkg
// Shared types and constants for the encoder index homing sequencer.
// ----------------------------------------------------------------------------
package eihs_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int CPR_W           = 20;
  localparam int STILL_W         = 10;
  localparam int FACTOR_W        = 12;
  localparam int CFG_DATA_W      = 20;
  localparam int CFG_IDX_W       = 2;
  localparam int OUT_W           = 32;

  localparam logic [CPR_W-1:0]    CPR_RESET    = 20'd4096;
  localparam logic [STILL_W-1:0]  STILL_RESET  = 10'd10;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 12'd256;
  localparam logic [STILL_W-1:0]  STILL_MAX    = 10'd1023;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNTS_PER_REV = 2'd0,
    REG_STILL_SAMPLES  = 2'd1,
    REG_STOP_FACTOR    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    DRIVE_STOP    = 2'd0,
    DRIVE_FORWARD = 2'd1,
    DRIVE_REVERSE = 2'd2
  } drive_t;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_FORWARD = 6'b000010,
    ST_BAND    = 6'b000100,
    ST_REST    = 6'b001000,
    ST_REVERSE = 6'b010000,
    ST_RETURN  = 6'b100000
  } stage_t;

  typedef struct packed {
    logic enc_a_rise;
    logic enc_b_level;
    logic laser_level;
    logic stop_sample;
    logic start_homing;
    logic abort;
  } item_t;

  typedef struct packed {
    logic [CPR_W-1:0]           counts_per_rev;
    logic [STILL_W-1:0]         still_samples;
    logic signed [FACTOR_W-1:0] stop_factor_q8;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              drive_cmd;
    logic [2:0]              stage_now;
    logic signed [OUT_W-1:0] position_out;
    logic signed [OUT_W-1:0] slop_out;
    logic signed [OUT_W-1:0] stop_err_out;
    logic                    done_pulse;
    logic                    aborted_pulse;
  } result_t;

  function automatic logic [2:0] stage_code(stage_t s);
    logic [2:0] c;
    case (s)
      ST_IDLE:    c = 3'd0;
      ST_FORWARD: c = 3'd1;
      ST_BAND:    c = 3'd2;
      ST_REST:    c = 3'd3;
      ST_REVERSE: c = 3'd4;
      ST_RETURN:  c = 3'd5;
      default:    c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic drive_t stage_drive(stage_t s);
    drive_t d;
    case (s)
      ST_FORWARD, ST_BAND:   d = DRIVE_FORWARD;
      ST_REVERSE, ST_RETURN: d = DRIVE_REVERSE;
      default:               d = DRIVE_STOP;
    endcase
    return d;
  endfunction

endpackage

// File: src/encoder_index_homing_sequencer_unit.sv
// ----------------------------------------------------------------------------
// encoder_index_homing_sequencer_unit
// Quadrature count and five-stage index homing sequence, one tick per beat.
// ----------------------------------------------------------------------------
// One tick beat is taken every clock cycle while the input is not stalled.
// A tick lands in an input register at the edge that accepts it; once the
// output register can take a result, the stage logic and count update run
// in one pass and the result lands in that register and on the result port.
// A stalled result holds the output register; the input stalls only while
// that register is full and stalled and a tick is already waiting.
// The longest path is the gain product formed when the rest wait ends: count
// update, stop difference and a multiply of the difference by the 12-bit gain.
// The goal in the reverse search stage is then two adds and a saturation.
// Configuration writes are always ready and take effect on the next tick;
// write them only while idle.
module encoder_index_homing_sequencer_unit #(
  parameter int COUNT_WIDTH = eihs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              enc_a_rise,
  input  logic                              enc_b_level,
  input  logic                              laser_level,
  input  logic                              stop_sample,
  input  logic                              start_homing,
  input  logic                              abort,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        drive_cmd,
  output logic [2:0]                        stage_now,
  output logic signed [eihs_pkg::OUT_W-1:0] position_out,
  output logic signed [eihs_pkg::OUT_W-1:0] slop_out,
  output logic signed [eihs_pkg::OUT_W-1:0] stop_err_out,
  output logic                              done_pulse,
  output logic                              aborted_pulse,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [eihs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [eihs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import eihs_pkg::*;

  cfg_t    cfg;
  item_t   in_item, held_item;
  logic    held_valid, can_load, fire;
  result_t core_result, out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.counts_per_rev <= CPR_RESET;
      cfg.still_samples  <= STILL_RESET;
      cfg.stop_factor_q8 <= $signed(FACTOR_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COUNTS_PER_REV: cfg.counts_per_rev <= cfg_data[CPR_W-1:0];
        REG_STILL_SAMPLES:  cfg.still_samples  <= cfg_data[STILL_W-1:0];
        REG_STOP_FACTOR:    cfg.stop_factor_q8 <= $signed(cfg_data[FACTOR_W-1:0]);
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  assign in_item = '{enc_a_rise:   enc_a_rise,
                     enc_b_level:  enc_b_level,
                     laser_level:  laser_level,
                     stop_sample:  stop_sample,
                     start_homing: start_homing,
                     abort:        abort};

  assign fire = held_valid && can_load;

  eihs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .fire       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  eihs_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (held_item),
    .cfg    (cfg),
    .result (core_result)
  );

  eihs_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (fire),
    .load_result (core_result),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .can_load    (can_load),
    .result      (out_result)
  );

  assign drive_cmd     = out_result.drive_cmd;
  assign stage_now     = out_result.stage_now;
  assign position_out  = out_result.position_out;
  assign slop_out      = out_result.slop_out;
  assign stop_err_out  = out_result.stop_err_out;
  assign done_pulse    = out_result.done_pulse;
  assign aborted_pulse = out_result.aborted_pulse;

  // input side backs up only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (held_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // an accepted tick is always held in the input register on the next cycle
  a_tick_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> held_valid)
    else $error("accepted tick not held");

  // a processed tick always shows up as a result beat
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed tick produced no result beat");

  // completion always leaves the count zeroed and the sequence idle
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_pulse) |-> (stage_now == stage_code(ST_IDLE)
                                   && position_out == '0 && !aborted_pulse))
    else $error("done beat with nonzero count or active stage");

endmodule

// File: src/eihs_in_reg.sv
// ----------------------------------------------------------------------------
// eihs_in_reg
// One-entry input register for tick beats; refills on the cycle it drains.
// ----------------------------------------------------------------------------
module eihs_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  eihs_pkg::item_t in_item,
  input  logic           fire,
  output logic           held_valid,
  output eihs_pkg::item_t held_item
);
  import eihs_pkg::*;

  assign in_stall = held_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_item <= in_item;
    end
  end

endmodule

// File: src/eihs_core.sv
// ----------------------------------------------------------------------------
// eihs_core
// Position count and homing stage logic; one tick handled per fire.
// ----------------------------------------------------------------------------
module eihs_core #(
  parameter int COUNT_WIDTH = eihs_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  eihs_pkg::item_t   item,
  input  eihs_pkg::cfg_t    cfg,
  output eihs_pkg::result_t result
);
  import eihs_pkg::*;

  localparam int W  = COUNT_WIDTH;
  localparam int CW = W + 22;
  localparam int PW = W + FACTOR_W;
  localparam int SW = W + 13;
  localparam int QW = SW - 8;

  stage_t              stage, stage_next;
  logic signed [W-1:0] position, position_next;
  logic signed [W-1:0] rise_count, rise_count_next;
  logic signed [W-1:0] fall_count, fall_count_next;
  logic signed [W-1:0] rest_count, rest_count_next;
  logic signed [W-1:0] prev_sample, prev_sample_next;
  logic [STILL_W-1:0]  still_counter, still_counter_next;
  logic signed [W-1:0] goal_count, goal_count_next;
  logic signed [W-1:0] slop_value, slop_value_next;
  logic signed [W-1:0] stop_value, stop_value_next;
  logic signed [W-1:0] mid, mid_next;
  logic signed [PW-1:0] prod, prod_next;

  logic signed [W-1:0]  pos_upd;
  logic signed [CW-1:0] pos_wide, limit_fwd, band_diff, band_half;
  logic signed [W:0]    mid_sum, mid_adj;
  logic signed [W-1:0]  stop_diff;
  logic signed [SW-1:0] q_sum, q_adj;
  logic signed [QW-1:0] q_div;
  logic signed [W-1:0]  goal_sat;
  logic [STILL_W-1:0]   still_upd;
  logic                 done, aborted;

  always_comb begin
    // b high adds one, b low adds all ones
    pos_upd = item.enc_a_rise ? position + $signed({{(W-1){~item.enc_b_level}}, 1'b1})
                              : position;
    pos_wide  = CW'(pos_upd);
    limit_fwd = $signed({{(W+1){1'b0}}, cfg.counts_per_rev, 1'b0});
    band_diff = pos_wide - CW'(rise_count);
    band_half = $signed({{(W+3){1'b0}}, cfg.counts_per_rev[CPR_W-1:1]});

    // midpoint of the sensor band, rounded toward zero
    mid_sum = (W+1)'(fall_count) + (W+1)'(rise_count);
    mid_adj = mid_sum + $signed({{W{1'b0}}, mid_sum[W]});

    stop_diff = pos_upd - rise_count;

    q_sum = (SW'(mid) <<< 8) + SW'(prod);
    q_adj = q_sum + (q_sum[SW-1] ? SW'(255) : SW'(0));
    q_div = q_adj[SW-1:8];
    if (q_div[QW-1:W-1] == {(QW-W+1){1'b0}} || q_div[QW-1:W-1] == {(QW-W+1){1'b1}}) begin
      goal_sat = q_div[W-1:0];
    end else if (q_div[QW-1]) begin
      goal_sat = $signed({1'b1, {(W-1){1'b0}}});
    end else begin
      goal_sat = $signed({1'b0, {(W-1){1'b1}}});
    end

    if (!item.stop_sample) begin
      still_upd = still_counter;
    end else if (prev_sample == pos_upd) begin
      still_upd = (still_counter < STILL_MAX) ? still_counter + 1'b1 : still_counter;
    end else begin
      still_upd = '0;
    end
  end

  always_comb begin
    stage_next         = stage;
    position_next      = pos_upd;
    rise_count_next    = rise_count;
    fall_count_next    = fall_count;
    rest_count_next    = rest_count;
    prev_sample_next   = prev_sample;
    still_counter_next = still_counter;
    goal_count_next    = goal_count;
    slop_value_next    = slop_value;
    stop_value_next    = stop_value;
    mid_next           = mid;
    prod_next          = prod;
    done               = 1'b0;
    aborted            = 1'b0;

    if (item.abort) begin
      if (stage != ST_IDLE) begin
        stage_next = ST_IDLE;
        aborted    = 1'b1;
      end
    end else begin
      case (stage)
        ST_IDLE: begin
          if (item.start_homing) begin
            position_next = '0;
            stage_next    = ST_FORWARD;
          end
        end
        ST_FORWARD: begin
          if (item.laser_level || pos_wide >= limit_fwd) begin
            rise_count_next = pos_upd;
            stage_next      = ST_BAND;
          end
        end
        ST_BAND: begin
          if (!(item.laser_level && band_diff < band_half)) begin
            fall_count_next    = pos_upd;
            prev_sample_next   = -pos_upd;
            still_counter_next = '0;
            stage_next         = ST_REST;
          end
        end
        ST_REST: begin
          if (item.stop_sample) begin
            prev_sample_next = pos_upd;
          end
          still_counter_next = still_upd;
          if (still_upd >= cfg.still_samples) begin
            // latch the gain product and midpoint ahead of the reverse search
            rest_count_next = pos_upd;
            mid_next        = mid_adj[W:1];
            prod_next       = stop_diff * cfg.stop_factor_q8;
            stage_next      = ST_REVERSE;
          end
        end
        ST_REVERSE: begin
          if (item.laser_level) begin
            stop_value_next = rest_count - rise_count;
            slop_value_next = fall_count - pos_upd;
            position_next   = fall_count;
            goal_count_next = goal_sat;
            stage_next      = ST_RETURN;
          end
        end
        ST_RETURN: begin
          if (!(pos_upd > goal_count)) begin
            position_next = '0;
            done          = 1'b1;
            stage_next    = ST_IDLE;
          end
        end
        default: begin
          stage_next = ST_IDLE;
        end
      endcase
    end

    result.drive_cmd     = stage_drive(stage_next);
    result.stage_now     = stage_code(stage_next);
    result.position_out  = OUT_W'(position_next);
    result.slop_out      = OUT_W'(slop_value_next);
    result.stop_err_out  = OUT_W'(stop_value_next);
    result.done_pulse    = done;
    result.aborted_pulse = aborted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= ST_IDLE;
      position      <= '0;
      rise_count    <= '0;
      fall_count    <= '0;
      rest_count    <= '0;
      prev_sample   <= '0;
      still_counter <= '0;
      goal_count    <= '0;
      slop_value    <= '0;
      stop_value    <= '0;
      mid           <= '0;
      prod          <= '0;
    end else if (fire) begin
      stage         <= stage_next;
      position      <= position_next;
      rise_count    <= rise_count_next;
      fall_count    <= fall_count_next;
      rest_count    <= rest_count_next;
      prev_sample   <= prev_sample_next;
      still_counter <= still_counter_next;
      goal_count    <= goal_count_next;
      slop_value    <= slop_value_next;
      stop_value    <= stop_value_next;
      mid           <= mid_next;
      prod          <= prod_next;
    end
  end

endmodule

// File: src/eihs_out_reg.sv
// ----------------------------------------------------------------------------
// eihs_out_reg
// Result register; holds a beat under stall and reloads as it is taken.
// ----------------------------------------------------------------------------
module eihs_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  eihs_pkg::result_t load_result,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              can_load,
  output eihs_pkg::result_t result
);
  import eihs_pkg::*;

  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_result;
    end
  end

endmodule
